>>> rtl/ipcc_pkg.sv
// Package for the issue port contention checker.
// Field widths, port and refusal codes, register indexes, control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipcc_pkg;

  localparam int UNIT_COUNT_DEF   = 8;
  localparam int TIME_BITS_DEF    = 48;
  localparam int ELEMENT_BITS_DEF = 8;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int PORT_W    = 3;
  localparam int UNIT_W    = 3;
  localparam int LAT_W     = 8;
  localparam int ASIZE_W   = 16;
  localparam int MERGED_W  = 8;
  localparam int PC_W      = 64;
  localparam int VLEN_W    = 16;
  localparam int CAUSE_W   = 3;
  localparam int VMS_W     = 7;

  localparam int GENERIC_LIMIT    = 3;
  localparam int SCALAR_MEM_LIMIT = 2;
  localparam int GATHER_SHIFT     = 6;

  localparam logic [CFG_W-1:0] VECTOR_BITS_RST   = 13'd256;
  localparam logic [CFG_W-1:0] DATAPATH_BITS_RST = 13'd128;

  typedef enum logic [PORT_W-1:0] {
    PORT_P0      = 3'd0,
    PORT_P1      = 3'd1,
    PORT_SMEM    = 3'd2,
    PORT_VMEM    = 3'd3,
    PORT_VALU    = 3'd4,
    PORT_GENERIC = 3'd5
  } port_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_PORT_FULL = 3'd1,
    CAUSE_VMEM_BUSY = 3'd2,
    CAUSE_VALU_BUSY = 3'd3,
    CAUSE_ALU_BUSY  = 3'd4
  } cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VECTOR_BITS   = 1'b0,
    CFG_DATAPATH_BITS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_commit;
    logic load_out;
  } ipcc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } ipcc_sts_t;

endpackage

`default_nettype wire

>>> rtl/ipcc_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on ipcc_pkg for the divisor width.
`timescale 1ns / 1ps
`default_nettype none

module ipcc_div
  import ipcc_pkg::*;
#(
  parameter int DIV_W = 25
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [CFG_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [CFG_W-1:0] dsr_r;
  logic [CFG_W:0]   trial;
  logic [CFG_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, dsr_r};
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CNT_W'(DIV_W);
      rem_nxt = '0;
      quo_nxt = dividend;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[CFG_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CFG_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> rtl/ipcc_dp.sv
// Datapath: captured beat, slot counters, busy times, config registers,
// refusal logic and result register. Depends on ipcc_pkg and ipcc_div.
`timescale 1ns / 1ps
`default_nettype none

module ipcc_dp
  import ipcc_pkg::*;
#(
  parameter int UNIT_COUNT   = UNIT_COUNT_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF,
  parameter int DIV_W        = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ipcc_cmd_t            cmd,
  output ipcc_sts_t                 sts,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_cycle_start,
  input  wire logic [TIME_BITS-1:0] in_now,
  input  wire logic [PORT_W-1:0]    in_port,
  input  wire logic [UNIT_W-1:0]    in_alu_unit,
  input  wire logic [LAT_W-1:0]     in_alu_latency,
  input  wire logic                 in_is_vector,
  input  wire logic                 in_is_memory,
  input  wire logic                 in_can_squash,
  input  wire logic [ASIZE_W-1:0]   in_access_size,
  input  wire logic [MERGED_W-1:0]  in_merged_count,
  input  wire logic [PC_W-1:0]      in_program_counter,
  input  wire logic [VLEN_W-1:0]    in_vector_length,
  output logic                      out_granted,
  output logic [CAUSE_W-1:0]        out_refusal_cause
);

  localparam int UIX_W     = $clog2(UNIT_COUNT);
  localparam int ELEM_LOG  = $clog2(ELEMENT_BITS);
  localparam int RCP_SHIFT = CFG_W + ELEM_LOG;
  localparam int RCP_VAL   = (2 ** RCP_SHIFT + ELEMENT_BITS - 1) / ELEMENT_BITS;
  localparam int PROD_W    = 2 * CFG_W + 1;
  localparam logic [1:0] GEN_LIM  = 2'(GENERIC_LIMIT);
  localparam logic [1:0] SMEM_LIM = 2'(SCALAR_MEM_LIMIT);

  // config
  logic [CFG_W-1:0] vector_bits_r, datapath_bits_r;

  // captured beat
  logic                 cs_r, vec_r, mem_r, squash_r;
  logic [TIME_BITS-1:0] now_r;
  logic [PORT_W-1:0]    port_r;
  logic [UNIT_W-1:0]    unit_r;
  logic [LAT_W-1:0]     lat_r;
  logic [ASIZE_W-1:0]   asize_r;
  logic [MERGED_W-1:0]  merged_r;
  logic [PC_W-1:0]      pc_r;
  logic [VLEN_W-1:0]    vlen_r;

  // state
  logic [1:0]           gen_r, gen_eff, gen_nxt;
  logic [1:0]           spt_r, spt_eff, spt_nxt;
  logic [1:0]           smem_r, smem_eff, smem_nxt;
  logic [VMS_W-1:0]     vms_r, vms_eff, vms_nxt;
  logic                 vas_r, vas_eff, vas_nxt;
  logic [TIME_BITS-1:0] unit_busy_r [UNIT_COUNT];
  logic [TIME_BITS-1:0] vmem_busy_r, valu_busy_r;
  logic [VLEN_W-1:0]    rem_len_r, rem_len_nxt;
  logic [PC_W-1:0]      last_pc_r;

  // division bookkeeping and result
  logic                 div_vmem_r, div_min1_r;
  cause_t               res_cause_r;
  logic                 out_granted_r;
  logic [CAUSE_W-1:0]   out_cause_r;

  cause_t               cause;
  logic                 grant;
  logic                 unit_ok;
  logic [UIX_W-1:0]     unit_ix;
  logic [VMS_W-1:0]     vm_limit;
  logic [PROD_W-1:0]    per_prod;
  logic [CFG_W-1:0]     per_reg;
  logic [VLEN_W-1:0]    per_reg_ext;
  logic [VLEN_W-1:0]    rem_new;
  logic                 full_reg;
  logic [MERGED_W:0]    merged_p1;
  logic [DIV_W-1:0]     dividend;
  logic [CFG_W-1:0]     divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     quotient;
  logic [DIV_W-1:0]     occ;

  assign unit_ok  = (unit_r != '0) && (int'(unit_r) < UNIT_COUNT);
  assign unit_ix  = UIX_W'(unit_r);
  assign vm_limit = squash_r ? VMS_W'(1) : vector_bits_r[CFG_W-1:GATHER_SHIFT];

  always_comb begin
    gen_eff  = cs_r ? '0 : gen_r;
    spt_eff  = cs_r ? '0 : spt_r;
    smem_eff = cs_r ? '0 : smem_r;
    vms_eff  = cs_r ? '0 : vms_r;
    vas_eff  = cs_r ? 1'b0 : vas_r;
    gen_nxt  = gen_eff;
    spt_nxt  = spt_eff;
    smem_nxt = smem_eff;
    vms_nxt  = vms_eff;
    vas_nxt  = vas_eff;
    cause    = CAUSE_NONE;
    case (port_r)
      PORT_GENERIC: begin
        if (gen_eff >= GEN_LIM) cause = CAUSE_PORT_FULL;
        else gen_nxt = gen_eff + 2'd1;
      end
      PORT_VMEM: begin
        if (vms_eff == '0 && vmem_busy_r > now_r) cause = CAUSE_VMEM_BUSY;
        else if (vms_eff >= vm_limit) cause = CAUSE_PORT_FULL;
        else vms_nxt = vms_eff + VMS_W'(1);
      end
      PORT_VALU: begin
        if (!vas_eff && valu_busy_r > now_r) cause = CAUSE_VALU_BUSY;
        else if (vas_eff) cause = CAUSE_PORT_FULL;
        else vas_nxt = 1'b1;
      end
      PORT_SMEM: begin
        if (smem_eff >= SMEM_LIM) cause = CAUSE_PORT_FULL;
        else smem_nxt = smem_eff + 2'd1;
      end
      PORT_P0, PORT_P1: begin
        if (spt_eff[port_r[0]] || gen_eff >= GEN_LIM) begin
          cause = CAUSE_PORT_FULL;
        end else begin
          spt_nxt[port_r[0]] = 1'b1;
          gen_nxt            = gen_eff + 2'd1;
        end
      end
      default: cause = CAUSE_PORT_FULL;
    endcase
    if (cause == CAUSE_NONE && unit_ok && unit_busy_r[unit_ix] > now_r) begin
      cause = CAUSE_ALU_BUSY;
    end
  end

  assign grant = (cause == CAUSE_NONE);

  // vector_bits / ELEMENT_BITS by reciprocal multiply
  assign per_prod    = PROD_W'(vector_bits_r) * PROD_W'(RCP_VAL);
  assign per_reg     = CFG_W'(per_prod >> RCP_SHIFT);
  assign per_reg_ext = VLEN_W'(per_reg);

  assign rem_new  = (last_pc_r != pc_r) ? vlen_r : rem_len_r;
  assign full_reg = (per_reg_ext < rem_new);

  always_comb begin
    rem_len_nxt = rem_new;
    if (vec_r && !mem_r) begin
      rem_len_nxt = (rem_new > per_reg_ext) ? rem_new - per_reg_ext : '0;
    end
  end

  assign merged_p1 = {1'b0, merged_r} + (MERGED_W + 1)'(1);

  always_comb begin
    if (mem_r) begin
      dividend = DIV_W'(asize_r) * DIV_W'(merged_p1);
    end else if (full_reg) begin
      dividend = DIV_W'(vector_bits_r);
    end else begin
      dividend = DIV_W'(rem_new) * DIV_W'(ELEMENT_BITS);
    end
  end

  assign divisor = (datapath_bits_r == '0) ? CFG_W'(1) : datapath_bits_r;

  assign sts.need_div = grant && vec_r && (!mem_r || squash_r);
  assign sts.div_done = div_done;

  ipcc_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.eval && sts.need_div),
    .dividend(dividend),
    .divisor (divisor),
    .done    (div_done),
    .quotient(quotient)
  );

  assign occ = (div_min1_r && quotient == '0) ? DIV_W'(1) : quotient;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_bits_r   <= VECTOR_BITS_RST;
      datapath_bits_r <= DATAPATH_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VECTOR_BITS:   vector_bits_r   <= cfg_wdata;
        CFG_DATAPATH_BITS: datapath_bits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cs_r     <= in_cycle_start;
      now_r    <= in_now;
      port_r   <= in_port;
      unit_r   <= in_alu_unit;
      lat_r    <= in_alu_latency;
      vec_r    <= in_is_vector;
      mem_r    <= in_is_memory;
      squash_r <= in_can_squash;
      asize_r  <= in_access_size;
      merged_r <= in_merged_count;
      pc_r     <= in_program_counter;
      vlen_r   <= in_vector_length;
    end
    if (cmd.eval) begin
      res_cause_r <= cause;
      div_vmem_r  <= mem_r;
      div_min1_r  <= !full_reg;
    end
    if (cmd.load_out) begin
      out_granted_r <= (res_cause_r == CAUSE_NONE);
      out_cause_r   <= res_cause_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= '0;
      spt_r       <= '0;
      smem_r      <= '0;
      vms_r       <= '0;
      vas_r       <= 1'b0;
      vmem_busy_r <= '0;
      valu_busy_r <= '0;
      rem_len_r   <= '0;
      last_pc_r   <= '0;
      for (int i = 0; i < UNIT_COUNT; i++) begin
        unit_busy_r[i] <= '0;
      end
    end else begin
      if (cmd.eval) begin
        gen_r  <= gen_nxt;
        spt_r  <= spt_nxt;
        smem_r <= smem_nxt;
        vms_r  <= vms_nxt;
        vas_r  <= vas_nxt;
        if (grant) begin
          if (unit_ok) begin
            unit_busy_r[unit_ix] <= now_r + TIME_BITS'(lat_r);
          end
          if (vec_r && mem_r && !squash_r) begin
            vmem_busy_r <= now_r;
          end
          rem_len_r <= rem_len_nxt;
          last_pc_r <= pc_r;
        end
      end
      if (cmd.div_commit) begin
        if (div_vmem_r) begin
          vmem_busy_r <= now_r + TIME_BITS'(quotient);
        end else begin
          valu_busy_r <= now_r + TIME_BITS'(occ);
        end
      end
    end
  end

  assign out_granted       = out_granted_r;
  assign out_refusal_cause = out_cause_r;

endmodule

`default_nettype wire

>>> rtl/ipcc_ctrl.sv
// Controller: sequences capture, evaluation, division wait and result hand-off.
// Depends on ipcc_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ipcc_ctrl
  import ipcc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output ipcc_cmd_t      cmd,
  input  wire ipcc_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_commit = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/issue_port_contention_checker.sv
// Issue port contention checker, top level. Depends on ipcc_pkg, ipcc_ctrl, ipcc_dp.
// Each beat is captured, evaluated, and its verdict loaded into the result register,
// which waits while a previous result is not yet taken. A granted vector ALU op or
// unit-stride vector access first waits for the serial divider by datapath_bits (one
// quotient bit per cycle, DIV_W = 25 at default widths). New beats wait for idle.
// Reset (synchronous, rst_n low): counters and busy times zero, config to defaults.
`timescale 1ns / 1ps
`default_nettype none

module issue_port_contention_checker
  import ipcc_pkg::*;
#(
  parameter int UNIT_COUNT   = UNIT_COUNT_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_cycle_start,
  input  wire logic [TIME_BITS-1:0] in_now,
  input  wire logic [PORT_W-1:0]    in_port,
  input  wire logic [UNIT_W-1:0]    in_alu_unit,
  input  wire logic [LAT_W-1:0]     in_alu_latency,
  input  wire logic                 in_is_vector,
  input  wire logic                 in_is_memory,
  input  wire logic                 in_can_squash,
  input  wire logic [ASIZE_W-1:0]   in_access_size,
  input  wire logic [MERGED_W-1:0]  in_merged_count,
  input  wire logic [PC_W-1:0]      in_program_counter,
  input  wire logic [VLEN_W-1:0]    in_vector_length,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_granted,
  output logic [CAUSE_W-1:0]        out_refusal_cause
);

  localparam int VMEM_DIV_W = ASIZE_W + MERGED_W + 1;
  localparam int VALU_DIV_W = VLEN_W + $clog2(ELEMENT_BITS + 1);
  localparam int DIV_W      = (VMEM_DIV_W > VALU_DIV_W) ? VMEM_DIV_W : VALU_DIV_W;

  ipcc_cmd_t cmd;
  ipcc_sts_t sts;

  ipcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ipcc_dp #(
    .UNIT_COUNT  (UNIT_COUNT),
    .TIME_BITS   (TIME_BITS),
    .ELEMENT_BITS(ELEMENT_BITS),
    .DIV_W       (DIV_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_cycle_start    (in_cycle_start),
    .in_now            (in_now),
    .in_port           (in_port),
    .in_alu_unit       (in_alu_unit),
    .in_alu_latency    (in_alu_latency),
    .in_is_vector      (in_is_vector),
    .in_is_memory      (in_is_memory),
    .in_can_squash     (in_can_squash),
    .in_access_size    (in_access_size),
    .in_merged_count   (in_merged_count),
    .in_program_counter(in_program_counter),
    .in_vector_length  (in_vector_length),
    .out_granted       (out_granted),
    .out_refusal_cause (out_refusal_cause)
  );

endmodule

`default_nettype wire

>>> tb/sv/ipcc_issue_monitor.sv
// Result checker for the issue port contention checker testbench.
// Mirrors slot counters and busy times, predicts each verdict and compares it
// with the result channel. Depends on ipcc_pkg.
`timescale 1ns / 1ps

module ipcc_issue_monitor
  import ipcc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_cycle_start,
  input  logic [TIME_BITS_DEF-1:0] in_now,
  input  logic [PORT_W-1:0]        in_port,
  input  logic [UNIT_W-1:0]        in_alu_unit,
  input  logic [LAT_W-1:0]         in_alu_latency,
  input  logic                     in_is_vector,
  input  logic                     in_is_memory,
  input  logic                     in_can_squash,
  input  logic [ASIZE_W-1:0]       in_access_size,
  input  logic [MERGED_W-1:0]      in_merged_count,
  input  logic [PC_W-1:0]          in_program_counter,
  input  logic [VLEN_W-1:0]        in_vector_length,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_granted,
  input  logic [CAUSE_W-1:0]       out_refusal_cause,
  output int                       fail_count,
  output int                       pending_beats,
  output int                       checked_beats,
  output int                       granted_beats
);

  localparam int TB = TIME_BITS_DEF;

  typedef struct {
    logic   granted;
    cause_t cause;
  } verdict_t;

  verdict_t expected_verdicts[$];

  logic [CFG_W-1:0] vector_q;
  logic [CFG_W-1:0] datapath_q;

  int unsigned      generic_used;
  int unsigned      smem_used;
  int unsigned      vmem_used;
  logic             valu_used;
  logic [1:0]       single_taken;
  logic [TB-1:0]    unit_busy[UNIT_COUNT_DEF];
  logic [TB-1:0]    vmem_busy;
  logic [TB-1:0]    valu_busy;
  logic [63:0]      remain_len;
  logic [PC_W-1:0]  prev_pc;

  int mismatches = 0;
  int checked    = 0;
  int granted_n  = 0;

  initial begin
    fail_count    = 0;
    pending_beats = 0;
    checked_beats = 0;
    granted_beats = 0;
  end

  task automatic report_failure(input string msg);
    if (mismatches < 10) $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic cause_t arbitrate_issue();
    cause_t        c;
    logic [TB-1:0] now_v;
    int            u;
    int unsigned   lim;
    logic [63:0]   dp;
    logic [63:0]   per_reg;
    logic [63:0]   occ;
    logic [63:0]   span;
    c = CAUSE_NONE;
    now_v = in_now;
    dp = (datapath_q == '0) ? 64'd1 : 64'(datapath_q);
    if (in_cycle_start) begin
      generic_used = 0;
      smem_used = 0;
      vmem_used = 0;
      valu_used = 1'b0;
      single_taken = '0;
    end
    u = (int'(in_alu_unit) < UNIT_COUNT_DEF) ? int'(in_alu_unit) : 0;
    case (in_port)
      PORT_GENERIC: begin
        if (generic_used >= GENERIC_LIMIT) c = CAUSE_PORT_FULL;
        else generic_used++;
      end
      PORT_VMEM: begin
        lim = in_can_squash ? 1 : int'(vector_q >> GATHER_SHIFT);
        if (vmem_used == 0 && vmem_busy > now_v) c = CAUSE_VMEM_BUSY;
        else if (vmem_used >= lim) c = CAUSE_PORT_FULL;
        else vmem_used++;
      end
      PORT_VALU: begin
        if (!valu_used && valu_busy > now_v) c = CAUSE_VALU_BUSY;
        else if (valu_used) c = CAUSE_PORT_FULL;
        else valu_used = 1'b1;
      end
      PORT_SMEM: begin
        if (smem_used >= SCALAR_MEM_LIMIT) c = CAUSE_PORT_FULL;
        else smem_used++;
      end
      PORT_P0, PORT_P1: begin
        if (single_taken[in_port[0]] || generic_used >= GENERIC_LIMIT) begin
          c = CAUSE_PORT_FULL;
        end else begin
          single_taken[in_port[0]] = 1'b1;
          generic_used++;
        end
      end
      default: c = CAUSE_PORT_FULL;
    endcase

    if (c == CAUSE_NONE && u != 0 && unit_busy[u] > now_v) c = CAUSE_ALU_BUSY;

    if (c == CAUSE_NONE) begin
      per_reg = 64'(vector_q) / 64'(ELEMENT_BITS_DEF);
      if (u != 0) unit_busy[u] = now_v + TB'(in_alu_latency);
      if (in_is_vector && in_is_memory) begin
        if (in_can_squash) begin
          span = (64'(in_access_size) * (64'(in_merged_count) + 64'd1)) / dp;
          vmem_busy = now_v + span[TB-1:0];
        end else begin
          vmem_busy = now_v;
        end
      end
      if (prev_pc != in_program_counter) remain_len = 64'(in_vector_length);
      if (in_is_vector && !in_is_memory) begin
        if (per_reg < remain_len) begin
          occ = 64'(vector_q) / dp;
        end else begin
          occ = (remain_len * 64'(ELEMENT_BITS_DEF)) / dp;
          if (occ == 0) occ = 64'd1;
        end
        valu_busy = now_v + occ[TB-1:0];
        remain_len = (remain_len > per_reg) ? remain_len - per_reg : 64'd0;
      end
      prev_pc = in_program_counter;
    end
    return c;
  endfunction

  always @(posedge clk) begin
    verdict_t head;
    verdict_t fresh;
    if (!rst_n) begin
      vector_q = VECTOR_BITS_RST;
      datapath_q = DATAPATH_BITS_RST;
      generic_used = 0;
      smem_used = 0;
      vmem_used = 0;
      valu_used = 1'b0;
      single_taken = '0;
      for (int i = 0; i < UNIT_COUNT_DEF; i++) unit_busy[i] = '0;
      vmem_busy = '0;
      valu_busy = '0;
      remain_len = '0;
      prev_pc = '0;
      expected_verdicts.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_VECTOR_BITS) vector_q = cfg_wdata;
        else if (cfg_index == CFG_DATAPATH_BITS) datapath_q = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (out_granted === 1'b1) granted_n++;
        if (expected_verdicts.size() == 0) begin
          report_failure($sformatf("unexpected result beat: granted=%0b cause=%0d",
                                   out_granted, out_refusal_cause));
        end else begin
          head = expected_verdicts.pop_front();
          checked++;
          if (out_granted !== head.granted || out_refusal_cause !== head.cause) begin
            report_failure($sformatf(
              "result %0d mismatch: expected granted=%0b cause=%0d, got granted=%0b cause=%0d",
              checked, head.granted, head.cause, out_granted, out_refusal_cause));
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh.cause = arbitrate_issue();
        fresh.granted = (fresh.cause == CAUSE_NONE);
        expected_verdicts.push_back(fresh);
      end
    end
    fail_count    <= mismatches;
    pending_beats <= expected_verdicts.size();
    checked_beats <= checked;
    granted_beats <= granted_n;
  end

endmodule

>>> tb/sv/issue_port_contention_checker_test.sv
// Top of the issue port contention checker testbench.
// Drives directed and random micro-op beats under several register settings,
// with random gaps on both channels; ipcc_issue_monitor does the checking.
`timescale 1ns / 1ps

module issue_port_contention_checker_test;
  import ipcc_pkg::*;

  localparam int RESET_CYCLES  = 5;
  localparam int PHASES        = 9;
  localparam int OPS_PER_PHASE = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int TB            = TIME_BITS_DEF;

  localparam logic [PORT_W-1:0] PORT_UNDEF_LO = 3'd6;
  localparam logic [PORT_W-1:0] PORT_UNDEF_HI = 3'd7;

  typedef struct {
    logic              cs;
    logic [TB-1:0]     now;
    logic [PORT_W-1:0] port;
    logic [UNIT_W-1:0] unit;
    logic [LAT_W-1:0]  lat;
    logic              vec;
    logic              mem;
    logic              sq;
    logic [ASIZE_W-1:0]  asize;
    logic [MERGED_W-1:0] merged;
    logic [PC_W-1:0]     pc;
    logic [VLEN_W-1:0]   vlen;
  } micro_op_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cycle_start = 1'b0;
  logic [TB-1:0]        in_now = '0;
  logic [PORT_W-1:0]    in_port = '0;
  logic [UNIT_W-1:0]    in_alu_unit = '0;
  logic [LAT_W-1:0]     in_alu_latency = '0;
  logic                 in_is_vector = 1'b0;
  logic                 in_is_memory = 1'b0;
  logic                 in_can_squash = 1'b0;
  logic [ASIZE_W-1:0]   in_access_size = '0;
  logic [MERGED_W-1:0]  in_merged_count = '0;
  logic [PC_W-1:0]      in_program_counter = '0;
  logic [VLEN_W-1:0]    in_vector_length = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_granted;
  logic [CAUSE_W-1:0]   out_refusal_cause;

  int fail_count;
  int pending_beats;
  int checked_beats;
  int granted_beats;

  logic          calm = 1'b0;
  int            ready_left = 0;
  int            idle_cycles = 0;
  int            sent_ops = 0;
  int            issue_left = 0;
  logic [TB-1:0] cur_now = '0;
  logic [PC_W-1:0] pc_pool[4];

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  issue_port_contention_checker i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cycle_start    (in_cycle_start),
    .in_now            (in_now),
    .in_port           (in_port),
    .in_alu_unit       (in_alu_unit),
    .in_alu_latency    (in_alu_latency),
    .in_is_vector      (in_is_vector),
    .in_is_memory      (in_is_memory),
    .in_can_squash     (in_can_squash),
    .in_access_size    (in_access_size),
    .in_merged_count   (in_merged_count),
    .in_program_counter(in_program_counter),
    .in_vector_length  (in_vector_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted       (out_granted),
    .out_refusal_cause (out_refusal_cause)
  );

  ipcc_issue_monitor i_monitor (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cycle_start    (in_cycle_start),
    .in_now            (in_now),
    .in_port           (in_port),
    .in_alu_unit       (in_alu_unit),
    .in_alu_latency    (in_alu_latency),
    .in_is_vector      (in_is_vector),
    .in_is_memory      (in_is_memory),
    .in_can_squash     (in_can_squash),
    .in_access_size    (in_access_size),
    .in_merged_count   (in_merged_count),
    .in_program_counter(in_program_counter),
    .in_vector_length  (in_vector_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted       (out_granted),
    .out_refusal_cause (out_refusal_cause),
    .fail_count        (fail_count),
    .pending_beats     (pending_beats),
    .checked_beats     (checked_beats),
    .granted_beats     (granted_beats)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: alternate ready bursts and stalls
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 1)) begin
        out_ready <= 1'b1;
        ready_left <= $urandom_range(1, 8);
      end else begin
        out_ready <= 1'b0;
        ready_left <= pick_gap();
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic micro_op_t mk_op(
    input logic cs, input logic [TB-1:0] now, input logic [PORT_W-1:0] port,
    input logic [UNIT_W-1:0] unit, input logic [LAT_W-1:0] lat,
    input logic vec, input logic mem, input logic sq,
    input logic [ASIZE_W-1:0] asize, input logic [MERGED_W-1:0] merged,
    input logic [PC_W-1:0] pc, input logic [VLEN_W-1:0] vlen);
    micro_op_t op;
    op.cs = cs; op.now = now; op.port = port; op.unit = unit; op.lat = lat;
    op.vec = vec; op.mem = mem; op.sq = sq; op.asize = asize;
    op.merged = merged; op.pc = pc; op.vlen = vlen;
    return op;
  endfunction

  function automatic micro_op_t random_micro_op();
    micro_op_t op;
    int noise;
    int r;
    if (issue_left == 0) begin
      issue_left = $urandom_range(1, 6);
      cur_now = cur_now + TB'($urandom_range(0, 4));
      op.cs = 1'b1;
    end else begin
      op.cs = 1'b0;
    end
    issue_left--;
    op.now = cur_now;
    if ($urandom_range(0, 99) < 5) begin
      op.port = PORT_W'($urandom_range(PORT_UNDEF_HI, PORT_UNDEF_LO));
    end else begin
      op.port = PORT_W'($urandom_range(PORT_GENERIC, PORT_P0));
    end
    op.vec = (op.port == PORT_VMEM) || (op.port == PORT_VALU);
    op.mem = (op.port == PORT_VMEM) || (op.port == PORT_SMEM);
    op.sq = 1'($urandom_range(0, 1));
    op.unit = UNIT_W'($urandom_range(0, 7));
    op.lat = ($urandom_range(0, 19) == 0) ? LAT_W'($urandom) : LAT_W'($urandom_range(0, 6));
    op.asize = ($urandom_range(0, 49) == 0) ? ASIZE_W'($urandom)
                                            : ASIZE_W'($urandom_range(1, 64));
    op.merged = ($urandom_range(0, 9) == 0) ? MERGED_W'($urandom)
                                            : MERGED_W'($urandom_range(0, 3));
    op.pc = pc_pool[$urandom_range(0, 3)];
    r = $urandom_range(0, 19);
    if (r == 0) op.vlen = '0;
    else if (r == 1) op.vlen = VLEN_W'($urandom);
    else op.vlen = VLEN_W'($urandom_range(1, 96));
    noise = $urandom_range(0, 99);
    if (noise >= 88) begin
      op.cs = 1'($urandom_range(0, 1));
      op.vec = 1'($urandom_range(0, 1));
      op.mem = 1'($urandom_range(0, 1));
      op.pc = {$urandom, $urandom};
      if (noise >= 97) op.now = TB'({$urandom, $urandom});
    end
    return op;
  endfunction

  task automatic send_op(input micro_op_t op);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_cycle_start     <= op.cs;
    in_now             <= op.now;
    in_port            <= op.port;
    in_alu_unit        <= op.unit;
    in_alu_latency     <= op.lat;
    in_is_vector       <= op.vec;
    in_is_memory       <= op.mem;
    in_can_squash      <= op.sq;
    in_access_size     <= op.asize;
    in_merged_count    <= op.merged;
    in_program_counter <= op.pc;
    in_vector_length   <= op.vlen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_ops++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] vb_list[PHASES];
    logic [CFG_W-1:0] dp_list[PHASES];
    logic [CFG_W-1:0] vb;
    logic [CFG_W-1:0] dp;
    logic [TB-1:0]    tmax;
    logic [PC_W-1:0]  pc_ones;
    vb_list = '{13'd256, 13'd64, 13'd4096, 13'd4096, 13'd64, 13'd8191, 13'd512, 13'd0, 13'd0};
    dp_list = '{13'd128, 13'd64, 13'd4096, 13'd64, 13'd4096, 13'd0, 13'd256, 13'd0, 13'd0};
    tmax = '1;
    pc_ones = '1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: slot limits, busy checks, kept slots, length tracking
    send_op(mk_op(1, 0, PORT_P0, 1, 3, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(0, 0, PORT_P0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(0, 0, PORT_P1, 2, 1, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(0, 0, PORT_GENERIC, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(0, 0, PORT_GENERIC, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(1, 1, PORT_SMEM, 1, 0, 0, 1, 0, 0, 0, 0, 0));
    send_op(mk_op(0, 1, PORT_SMEM, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    send_op(mk_op(0, 1, PORT_SMEM, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    send_op(mk_op(1, 2, PORT_VMEM, 0, 0, 1, 1, 1, 16'hFFFF, 8'hFF, 0, 0));
    send_op(mk_op(1, 3, PORT_VMEM, 0, 0, 1, 1, 1, 1, 0, 0, 0));
    send_op(mk_op(0, 3, PORT_UNDEF_LO, 3, 2, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(0, 3, PORT_UNDEF_HI, 0, 0, 1, 1, 1, 0, 0, pc_ones, 16'hFFFF));
    send_op(mk_op(1, 4, PORT_VALU, 0, 0, 1, 0, 0, 0, 0, pc_ones, 16'hFFFF));
    send_op(mk_op(1, 5, PORT_VALU, 0, 0, 1, 0, 0, 0, 0, pc_ones, 16'hFFFF));
    send_op(mk_op(1, 6, PORT_VALU, 0, 0, 1, 0, 0, 0, 0, pc_ones, 16'hFFFF));
    send_op(mk_op(1, 7, PORT_VALU, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(1, 8, PORT_VALU, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(0, 8, PORT_VALU, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(1, tmax, PORT_P0, 7, 8'hFF, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(1, tmax, PORT_GENERIC, 7, 0, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(1, TB'(1) << 40, PORT_VMEM, 0, 0, 1, 1, 0, 8, 0, 0, 0));
    repeat (4) send_op(mk_op(0, TB'(1) << 40, PORT_VMEM, 0, 0, 1, 1, 0, 8, 0, 0, 0));

    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_beats != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      vb = (p >= 7) ? CFG_W'($urandom_range(64, 4096)) : vb_list[p];
      dp = (p >= 7) ? CFG_W'($urandom_range(64, 4096)) : dp_list[p];
      write_reg(CFG_VECTOR_BITS, vb);
      write_reg(CFG_DATAPATH_BITS, dp);
      cfg_we <= 1'b0;
      calm <= (p == 2) || (p == 6);
      if (p == PHASES - 1) cur_now = tmax - TB'(150);
      else cur_now = {4'(p + 1), 44'({$urandom, $urandom})};
      pc_pool[0] = {$urandom, $urandom};
      pc_pool[1] = pc_pool[0] + 64'd4;
      pc_pool[2] = {$urandom, $urandom};
      pc_pool[3] = ~pc_pool[0];
      issue_left = 0;
      repeat (OPS_PER_PHASE) send_op(random_micro_op());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d micro-op beats over %0d register settings, directed then random.",
             sent_ops, PHASES + 1);
    $display("Results checked: %0d, granted %0d, refused %0d, still awaited %0d.",
             checked_beats, granted_beats, checked_beats - granted_beats, pending_beats);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> issue_port_contention_checker.f
rtl/ipcc_pkg.sv
rtl/ipcc_div.sv
rtl/ipcc_dp.sv
rtl/ipcc_ctrl.sv
rtl/issue_port_contention_checker.sv
tb/sv/ipcc_issue_monitor.sv
tb/sv/issue_port_contention_checker_test.sv
